// ----- src/overwriting_byte_ring_queue_defines.svh -----
// assertion macros for the byte ring queue checker
`ifndef OVERWRITING_BYTE_RING_QUEUE_DEFINES_SVH
`define OVERWRITING_BYTE_RING_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OBRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define OBRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/obrq_pkg.sv -----
// shared types and constants for the byte ring queue
package obrq_pkg;

    localparam int DATA_W        = 8;
    localparam int CNT_W         = 8;
    localparam int MAX_DEPTH_DEF = 128;
    localparam logic [CNT_W-1:0] QSIZE_RST = 8'd128;

    typedef enum logic [0:0]
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic exec;
        logic clear;
    } obrq_cmd_t;

endpackage

// ----- src/obrq_in_if.sv -----
// request channel: push or pop beats
interface obrq_in_if
    import obrq_pkg::*;
();
    logic              valid;
    logic              ready;
    opcode_t           opcode;
    logic [DATA_W-1:0] data_in;

    modport source
    (
        output valid,
        input  ready,
        output opcode,
        output data_in
    );

    modport sink
    (
        input  valid,
        output ready,
        input  opcode,
        input  data_in
    );
endinterface

// ----- src/obrq_out_if.sv -----
// response channel: popped byte, status and fill count
interface obrq_out_if
    import obrq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              pop_ok;
    logic [CNT_W-1:0]  fill_count;

    modport source
    (
        output valid,
        input  ready,
        output data_out,
        output pop_ok,
        output fill_count
    );

    modport sink
    (
        input  valid,
        output ready,
        input  data_out,
        input  pop_ok,
        input  fill_count
    );
endinterface

// ----- src/overwriting_byte_ring_queue.sv -----
// the result beat is valid in the cycle after the request beat is accepted
// throughput: one beat per cycle while the response side takes results
// the byte store has one write and one registered read port, used once per beat
// reset clears indices and count and sets queue size to 128; store contents undefined
// a queue size write empties the queue at once
module overwriting_byte_ring_queue
    import obrq_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    obrq_in_if.sink          req,
    obrq_out_if.source       rsp,
    input  logic             queue_size_we,
    input  logic [CNT_W-1:0] queue_size
);

    obrq_cmd_t cmd;

    obrq_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_ready     (req.ready),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .queue_size_we (queue_size_we),
        .cmd           (cmd)
    );

    obrq_dpath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .queue_size (queue_size),
        .opcode     (req.opcode),
        .data_in    (req.data_in),
        .data_out   (rsp.data_out),
        .pop_ok     (rsp.pop_ok),
        .fill_count (rsp.fill_count)
    );

endmodule

// ----- src/obrq_ctrl.sv -----
// handshake controller for the byte ring queue
module obrq_ctrl
    import obrq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  logic      queue_size_we,
    output obrq_cmd_t cmd
);

    typedef enum logic [0:0]
    {
        ST_IDLE,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign req_ready = (state_reg == ST_IDLE) || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = (state_reg == ST_HOLD);

    assign cmd.exec  = accept;
    assign cmd.clear = queue_size_we;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (accept)
                begin
                    state_next = ST_HOLD;
                end
                else if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/obrq_dpath.sv -----
// storage, indices, count and result registers of the byte ring queue
module obrq_dpath
    import obrq_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  obrq_cmd_t         cmd,
    input  logic [CNT_W-1:0]  queue_size,
    input  opcode_t           opcode,
    input  logic [DATA_W-1:0] data_in,
    output logic [DATA_W-1:0] data_out,
    output logic              pop_ok,
    output logic [CNT_W-1:0]  fill_count
);

    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CMP_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(MAX_DEPTH);
    localparam logic [CMP_W-1:0] ONE_CMP   = CMP_W'(1);

    logic [DATA_W-1:0] mem [MAX_DEPTH];

    logic [CNT_W-1:0]  qsize_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  rd_idx_next;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [IDX_W-1:0]  wr_idx_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic              pop_ok_reg;
    logic [CNT_W-1:0]  fill_reg;

    logic [CMP_W-1:0]  size_ext;
    logic [CMP_W-1:0]  size_act;
    logic [CMP_W-1:0]  rd_inc;
    logic [CMP_W-1:0]  wr_inc;
    logic [IDX_W-1:0]  rd_adv;
    logic [IDX_W-1:0]  wr_adv;
    logic              full;
    logic              do_push;
    logic              do_pop;

    // clamp size into 1..MAX_DEPTH
    assign size_ext = CMP_W'(qsize_reg);

    always_comb
    begin
        priority if (qsize_reg == '0)
        begin
            size_act = ONE_CMP;
        end
        else if (size_ext > DEPTH_CMP)
        begin
            size_act = DEPTH_CMP;
        end
        else
        begin
            size_act = size_ext;
        end
    end

    // wrap by compare
    assign rd_inc = CMP_W'(rd_idx_reg) + ONE_CMP;
    assign wr_inc = CMP_W'(wr_idx_reg) + ONE_CMP;
    assign rd_adv = (rd_inc >= size_act) ? '0 : IDX_W'(rd_inc);
    assign wr_adv = (wr_inc >= size_act) ? '0 : IDX_W'(wr_inc);

    assign full    = CMP_W'(count_reg) >= size_act;
    assign do_push = cmd.exec && (opcode == OP_PUSH);
    assign do_pop  = cmd.exec && (opcode == OP_POP) && (count_reg != '0);

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        count_next  = count_reg;
        priority if (do_push)
        begin
            wr_idx_next = wr_adv;
            if (full)
            begin
                rd_idx_next = rd_adv;
                count_next  = CNT_W'(size_act);
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (do_pop)
        begin
            rd_idx_next = rd_adv;
            count_next  = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qsize_reg  <= QSIZE_RST;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            count_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            qsize_reg  <= queue_size;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            count_reg  <= count_next;
        end
    end

    // byte store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_idx_reg] <= data_in;
        end
        if (do_pop)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            pop_ok_reg <= do_pop;
            fill_reg   <= count_next;
        end
    end

    assign data_out   = pop_ok_reg ? rd_data_reg : '0;
    assign pop_ok     = pop_ok_reg;
    assign fill_count = fill_reg;

endmodule

// ----- src/obrq_checker.sv -----
// port-level checks for the byte ring queue, bound to the top level
`include "overwriting_byte_ring_queue_defines.svh"

module obrq_checker
    import obrq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input opcode_t           req_opcode,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [DATA_W-1:0] rsp_data_out,
    input logic              rsp_pop_ok,
    input logic [CNT_W-1:0]  rsp_fill_count
);

    `OBRQ_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_pop_ok, rsp_data_out == '0, "nonzero data without pop")
    `OBRQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fill_count), "response dropped while stalled")
    `OBRQ_ASSERT_NEXT(a_push_rsp, req_valid && req_ready && (req_opcode == OP_PUSH), rsp_valid && !rsp_pop_ok && (rsp_fill_count != '0), "bad push response")
    `OBRQ_ASSERT_NEXT(a_pop_rsp, req_valid && req_ready && (req_opcode == OP_POP), rsp_valid && (rsp_pop_ok || (rsp_fill_count == '0)), "pop failed on nonempty queue")

endmodule

bind overwriting_byte_ring_queue obrq_checker u_obrq_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_opcode     (req.opcode),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_data_out   (rsp.data_out),
    .rsp_pop_ok     (rsp.pop_ok),
    .rsp_fill_count (rsp.fill_count)
);

// ----- tb/sv/overwriting_byte_ring_queue_checker.sv -----
// beat monitor and ring predictor for the byte ring queue testbench
`timescale 1ns / 100ps

module overwriting_byte_ring_queue_checker
    import obrq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    obrq_in_if               req,
    obrq_out_if              rsp,
    input  logic             size_we,
    input  logic [CNT_W-1:0] size_value,
    output int               errors,
    output int               pending,
    output int               checked,
    output int               overwrites,
    output int               empty_pops
);

    localparam int IDX_W = $clog2(MAX_DEPTH_DEF);

    typedef struct packed
    {
        logic [DATA_W-1:0] data_out;
        logic              pop_ok;
        logic [CNT_W-1:0]  fill_count;
    } ring_rsp_t;

    logic [DATA_W-1:0] ring_mem [MAX_DEPTH_DEF];
    logic [IDX_W-1:0]  head;
    logic [IDX_W-1:0]  tail;
    logic [CNT_W-1:0]  depth;
    logic [CNT_W-1:0]  size_reg;

    ring_rsp_t rsp_owed [$];

    int err_cnt;
    int seen_cnt;
    int over_cnt;
    int empty_cnt;

    function automatic logic [IDX_W-1:0] wrap_next(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] lim);
        logic [CNT_W:0] n;
        n = {2'b00, idx} + 1'b1;
        return (n >= {1'b0, lim}) ? '0 : n[IDX_W-1:0];
    endfunction

    function automatic ring_rsp_t ring_update(opcode_t op, logic [DATA_W-1:0] d);
        ring_rsp_t        r;
        logic [CNT_W-1:0] lim;
        r = '0;
        // size 0 behaves as 1, anything above the depth is clamped
        if (size_reg == '0)
            lim = CNT_W'(1);
        else if (size_reg > CNT_W'(MAX_DEPTH_DEF))
            lim = CNT_W'(MAX_DEPTH_DEF);
        else
            lim = size_reg;
        if ({1'b0, head} >= lim)
            head = '0;
        if ({1'b0, tail} >= lim)
            tail = '0;
        if (op == OP_PUSH)
        begin
            ring_mem[tail] = d;
            tail = wrap_next(tail, lim);
            if (depth >= lim)
            begin
                // full: drop the oldest byte
                head = wrap_next(head, lim);
                depth = lim;
                over_cnt++;
            end
            else
            begin
                depth = depth + 1'b1;
            end
        end
        else if (depth != '0)
        begin
            r.data_out = ring_mem[head];
            r.pop_ok = 1'b1;
            head = wrap_next(head, lim);
            depth = depth - 1'b1;
        end
        else
        begin
            empty_cnt++;
        end
        r.fill_count = depth;
        return r;
    endfunction

    always @(posedge clk)
    begin
        ring_rsp_t want;
        if (!rst_n)
        begin
            head = '0;
            tail = '0;
            depth = '0;
            size_reg = QSIZE_RST;
            rsp_owed.delete();
            err_cnt = 0;
            seen_cnt = 0;
            over_cnt = 0;
            empty_cnt = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (rsp_owed.size() == 0)
                begin
                    $error("result beat with no request outstanding: data_out=%0d pop_ok=%0d fill_count=%0d",
                           rsp.data_out, rsp.pop_ok, rsp.fill_count);
                    err_cnt++;
                end
                else
                begin
                    want = rsp_owed.pop_front();
                    seen_cnt++;
                    if (rsp.data_out !== want.data_out)
                    begin
                        $error("data_out: expected %0d, actual %0d", want.data_out, rsp.data_out);
                        err_cnt++;
                    end
                    if (rsp.pop_ok !== want.pop_ok)
                    begin
                        $error("pop_ok: expected %0d, actual %0d", want.pop_ok, rsp.pop_ok);
                        err_cnt++;
                    end
                    if (rsp.fill_count !== want.fill_count)
                    begin
                        $error("fill_count: expected %0d, actual %0d",
                               want.fill_count, rsp.fill_count);
                        err_cnt++;
                    end
                end
            end
            if (size_we)
            begin
                // size write empties the queue
                size_reg = size_value;
                head = '0;
                tail = '0;
                depth = '0;
            end
            if (req.valid && req.ready)
                rsp_owed.push_back(ring_update(req.opcode, req.data_in));
        end
        errors <= err_cnt;
        pending <= rsp_owed.size();
        checked <= seen_cnt;
        overwrites <= over_cnt;
        empty_pops <= empty_cnt;
    end

endmodule

// ----- tb/sv/overwriting_byte_ring_queue_tb.sv -----
// top of the byte ring queue testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module overwriting_byte_ring_queue_tb;
    import obrq_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    opcode_t           req_op = OP_PUSH;
    logic [DATA_W-1:0] req_data = '0;
    logic              rsp_take = 1'b0;
    logic              size_we = 1'b0;
    logic [CNT_W-1:0]  size_val = QSIZE_RST;

    int gap_pct = 0;
    int stall_pct = 0;
    int beats_sent = 0;
    int size_writes = 0;

    int errors;
    int pending;
    int checked;
    int overwrites;
    int empty_pops;

    obrq_in_if  req_ch ();
    obrq_out_if rsp_ch ();

    assign req_ch.valid   = req_valid;
    assign req_ch.opcode  = req_op;
    assign req_ch.data_in = req_data;
    assign rsp_ch.ready   = rsp_take;

    overwriting_byte_ring_queue DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .queue_size_we (size_we),
        .queue_size    (size_val)
    );

    overwriting_byte_ring_queue_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .size_we    (size_we),
        .size_value (size_val),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .overwrites (overwrites),
        .empty_pops (empty_pops)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        rsp_take <= rst_n && ($urandom_range(99) >= stall_pct);

    task automatic send_beat(opcode_t op, logic [DATA_W-1:0] d);
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_op <= op;
        req_data <= d;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic hold_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_size(logic [CNT_W-1:0] v);
        hold_until_drained();
        size_we <= 1'b1;
        size_val <= v;
        @(posedge clk);
        size_we <= 1'b0;
        size_writes++;
    endtask

    task automatic run_phase(logic [CNT_W-1:0] sz, int n_items, int mode, bit mid_drain);
        int      live;
        int      left;
        int      burst;
        int      push_pct;
        opcode_t op;
        write_size(sz);
        live = (sz == 0) ? 1 : ((sz > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : int'(sz));
        case (mode)
            1:       begin gap_pct = 68; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 68; end
            3:       begin gap_pct = 31; stall_pct = 31; end
            default: begin gap_pct = 0;  stall_pct = 0;  end
        endcase
        left = n_items;
        while (left > 0)
        begin
            // burst lengths of 1 to 2*live+4 beats, so a burst can fill past full or drain past empty
            burst = $urandom_range(2 * live + 4, 1);
            case ($urandom_range(3))
                0:       push_pct = 90;
                1:       push_pct = 60;
                2:       push_pct = 50;
                default: push_pct = 15;
            endcase
            for (int k = 0; k < burst && left > 0; k++)
            begin
                op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
                send_beat(op, DATA_W'($urandom_range(255)));
                left--;
                if (mid_drain && left == n_items / 2)
                    hold_until_drained();
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size, empty pop and byte extremes
        send_beat(OP_POP, 8'h3C);
        send_beat(OP_PUSH, 8'h00);
        send_beat(OP_PUSH, 8'hFF);
        send_beat(OP_POP, 8'hFF);
        send_beat(OP_POP, 8'h00);
        send_beat(OP_POP, 8'hA5);

        // single slot, overwrite on full
        write_size(8'd1);
        send_beat(OP_PUSH, 8'hA5);
        send_beat(OP_PUSH, 8'h5A);
        send_beat(OP_POP, 8'h00);
        send_beat(OP_POP, 8'hFF);

        // size zero behaves as one
        write_size(8'd0);
        send_beat(OP_PUSH, 8'h81);
        send_beat(OP_PUSH, 8'h7E);
        send_beat(OP_POP, 8'h42);

        // wrap and overwrite on a small ring
        write_size(8'd3);
        send_beat(OP_PUSH, 8'h11);
        send_beat(OP_PUSH, 8'h22);
        send_beat(OP_PUSH, 8'h33);
        send_beat(OP_PUSH, 8'h44);
        send_beat(OP_POP, 8'h99);
        send_beat(OP_POP, 8'h66);
        send_beat(OP_POP, 8'hCC);
        send_beat(OP_POP, 8'h0F);

        run_phase(8'd128, 260, 0, 1'b1);
        run_phase(8'd1,   120, 1, 1'b0);
        run_phase(8'd7,   120, 2, 1'b0);
        run_phase(8'd64,  260, 3, 1'b0);
        run_phase(8'd0,   120, 0, 1'b0);
        run_phase(8'd255, 260, 1, 1'b0);
        run_phase(8'd3,   120, 2, 1'b0);
        run_phase(8'd127, 260, 3, 1'b1);
        run_phase(8'd2,   120, 0, 1'b0);

        hold_until_drained();
        repeat (2) @(posedge clk);

        $display("covered %0d request beats over %0d queue size writes, %0d result beats checked",
                 beats_sent, size_writes, checked);
        $display("full-queue overwrites: %0d, pops on an empty queue: %0d",
                 overwrites, empty_pops);
        if (errors == 0 && pending == 0)
            $display("overwriting_byte_ring_queue regression: pass");
        else
            $display("overwriting_byte_ring_queue regression: fail");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("overwriting_byte_ring_queue regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/obrq_pkg.sv
src/obrq_in_if.sv
src/obrq_out_if.sv
src/obrq_ctrl.sv
src/obrq_dpath.sv
src/overwriting_byte_ring_queue.sv
src/obrq_checker.sv
tb/sv/overwriting_byte_ring_queue_checker.sv
tb/sv/overwriting_byte_ring_queue_tb.sv
